// File: design/hhv_pkg.sv
// Shared types and constants for the HTTP Host header validator.
package hhv_pkg;

	localparam int MAX_VALUE_LEN = 4096;
	localparam int POS_W         = $clog2(MAX_VALUE_LEN + 1);
	localparam int HLEN_W        = 13;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef enum logic [1:0] {
		MODE_USUAL   = 2'd0,
		MODE_LITERAL = 2'd1,
		MODE_REST    = 2'd2
	} scan_mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_SLASH     = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

endpackage

// File: design/http_host_header_validator.sv
// HTTP Host header validator: byte-wise scan, lowering and final status report.
//
//  channel | signals                          | direction | transaction
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid in_ready in_byte in_last| into      | one byte of the value
//  out     | out_valid out_ready out_byte     | out of    | one byte plus status and
//          | out_last status host_length      |           | length on the final byte
//
// One transaction in, one transaction out; a new byte can be taken every cycle while the
// output keeps up. The scan state is updated at the edge that accepts a byte, and
// the result lands in a single output register the same edge.
// in_ready is high whenever the output register is empty or being drained this cycle,
// so a stalled output only holds the input back while its result is still unread.
// Reset (arst_n low) clears the scan state and empties the output register.
module http_host_header_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [1:0]  status,
	output logic [12:0] host_length
);

	localparam int PW = hhv_pkg::POS_W;
	localparam int HW = hhv_pkg::HLEN_W;

	// Per-value scan state
	hhv_pkg::scan_mode_t mode_q, mode_n;
	logic [PW-1:0]       pos_q, pos_n;
	logic                dot_seen_q, dot_seen_n;
	logic [PW-1:0]       last_dot_q, last_dot_n;
	logic                hend_set_q, hend_set_n;
	logic [PW-1:0]       hend_q, hend_n;
	hhv_pkg::status_t    err_q, err_n;

	// Result register
	logic                out_valid_q;
	logic [7:0]          out_byte_q, ob;
	logic                out_last_q;
	hhv_pkg::status_t    status_q, st;
	logic [HW-1:0]       hlen_q, hl;

	// Final-byte length work
	logic [PW-1:0]       h, h_adj;
	logic                trail;

	logic accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Scan of one byte, then the end-of-value report on the updated state.
	always_comb begin
		mode_n     = mode_q;
		pos_n      = pos_q;
		dot_seen_n = dot_seen_q;
		last_dot_n = last_dot_q;
		hend_set_n = hend_set_q;
		hend_n     = hend_q;
		err_n      = err_q;
		ob         = in_byte;
		st         = hhv_pkg::ST_OK;
		hl         = '0;

		if (err_q == hhv_pkg::ST_OK) begin
			if (pos_q >= PW'(hhv_pkg::MAX_VALUE_LEN)) begin
				// over-long value: this byte goes through untouched
				err_n = hhv_pkg::ST_MALFORMED;
			end else begin
				case (in_byte)
					hhv_pkg::CH_DOT: begin
						// two dots in a row
						if (dot_seen_q && pos_q != '0 && last_dot_q == pos_q - 1'b1) begin
							err_n = hhv_pkg::ST_MALFORMED;
						end else begin
							dot_seen_n = 1'b1;
							last_dot_n = pos_q;
						end
					end
					hhv_pkg::CH_COLON: begin
						// port colon ends the host, not inside a literal
						if (mode_q == hhv_pkg::MODE_USUAL) begin
							hend_n     = pos_q;
							hend_set_n = 1'b1;
							mode_n     = hhv_pkg::MODE_REST;
						end
					end
					hhv_pkg::CH_LBRK: begin
						if (pos_q == '0) begin
							mode_n = hhv_pkg::MODE_LITERAL;
						end
					end
					hhv_pkg::CH_RBRK: begin
						// closing bracket is part of the host
						if (mode_q == hhv_pkg::MODE_LITERAL) begin
							hend_n     = pos_q + 1'b1;
							hend_set_n = 1'b1;
							mode_n     = hhv_pkg::MODE_REST;
						end
					end
					hhv_pkg::CH_NUL: begin
						err_n = hhv_pkg::ST_MALFORMED;
					end
					hhv_pkg::CH_SLASH: begin
						err_n = hhv_pkg::ST_SLASH;
					end
					default: begin
						if (in_byte inside {[8'h41:8'h5A]}) begin
							ob = in_byte + hhv_pkg::CASE_OFS;
						end
					end
				endcase
				if (err_n == hhv_pkg::ST_OK) begin
					pos_n = pos_q + 1'b1;
				end
			end
		end

		// host length: up to the colon/bracket, else the whole value
		h     = hend_set_n ? hend_n : pos_n;
		trail = (h != '0) && dot_seen_n && (last_dot_n == h - 1'b1);
		h_adj = trail ? h - 1'b1 : h;

		if (in_last) begin
			if (err_n != hhv_pkg::ST_OK) begin
				st = err_n;
			end else if (h_adj == '0) begin
				st = hhv_pkg::ST_EMPTY;
			end else begin
				hl = HW'(h_adj);
			end
			// fresh state for the next value
			mode_n     = hhv_pkg::MODE_USUAL;
			pos_n      = '0;
			dot_seen_n = 1'b0;
			last_dot_n = '0;
			hend_set_n = 1'b0;
			hend_n     = '0;
			err_n      = hhv_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= hhv_pkg::MODE_USUAL;
			pos_q       <= '0;
			dot_seen_q  <= 1'b0;
			last_dot_q  <= '0;
			hend_set_q  <= 1'b0;
			hend_q      <= '0;
			err_q       <= hhv_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q     <= mode_n;
				pos_q      <= pos_n;
				dot_seen_q <= dot_seen_n;
				last_dot_q <= last_dot_n;
				hend_set_q <= hend_set_n;
				hend_q     <= hend_n;
				err_q      <= err_n;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the result register, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= ob;
			out_last_q <= in_last;
			status_q   <= st;
			hlen_q     <= hl;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign out_last    = out_last_q;
	assign status      = status_q;
	assign host_length = hlen_q;

	// A result that does not end a value carries no status or length.
	a_mid_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (status_q == hhv_pkg::ST_OK && hlen_q == '0))
		else $error("status or length on a non-final byte");

	// An ok report always has a non-zero host length.
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q && status_q == hhv_pkg::ST_OK) |-> (hlen_q != '0))
		else $error("ok status with empty host");

	// The final byte of a value leaves the scan state clear.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (pos_q == '0 && err_q == hhv_pkg::ST_OK && !hend_set_q))
		else $error("scan state not cleared after final byte");

	// Once set, an error sticks until the value ends.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != hhv_pkg::ST_OK && !(accept && in_last)) |=> (err_q == $past(err_q)))
		else $error("error code changed within a value");

	// Nothing new enters while a result waits unread.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while output stalled");

endmodule

// File: test/tb_http_host_header_validator.sv
// Testbench for the HTTP Host header validator: directed and random values against a predictor.
`timescale 1ns / 100ps

module tb_http_host_header_validator;

	// One queued byte stream for a whole header value, first byte at the front.
	typedef logic [7:0] host_bytes_t[$];

	// What the block should hand back for one input transaction.
	typedef struct packed {
		logic [7:0]                 data;
		logic                       last;
		hhv_pkg::status_t           st;
		logic [hhv_pkg::HLEN_W-1:0] hlen;
	} host_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        in_last;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        out_last;
	logic [1:0]  status;
	logic [12:0] host_length;

	http_host_header_validator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.in_last     (in_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_last    (out_last),
		.status      (status),
		.host_length (host_length)
	);

	// Predicted transactions, oldest first.
	host_result_t host_results_q[$];

	// Predictor's own copy of the scan state.
	hhv_pkg::scan_mode_t       cur_mode;
	logic [hhv_pkg::POS_W-1:0] cur_pos;
	logic                      dot_hit;
	logic [hhv_pkg::POS_W-1:0] dot_idx;
	logic                      end_fixed;
	logic [hhv_pkg::POS_W-1:0] end_idx;
	hhv_pkg::status_t          first_err;

	// Run bookkeeping.
	int errors;
	int bytes_sent;
	int values_sent;
	int results_checked;
	int status_count[4];

	// Idling controls: per-transaction gaps on each side, plus a one-off long hold on the receiver.
	bit tx_idle_on;
	bit rx_idle_on;
	int rx_hold;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("http_host_header_validator: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_scan();
		cur_mode  = hhv_pkg::MODE_USUAL;
		cur_pos   = '0;
		dot_hit   = 1'b0;
		dot_idx   = '0;
		end_fixed = 1'b0;
		end_idx   = '0;
		first_err = hhv_pkg::ST_OK;
	endfunction

	// Works out the result of one accepted byte and advances the scan state.
	function automatic host_result_t scan_host_byte(logic [7:0] b, logic l);
		host_result_t              r;
		logic [hhv_pkg::POS_W-1:0] h;
		r.data = b;
		r.last = l;
		r.st   = hhv_pkg::ST_OK;
		r.hlen = '0;
		if (first_err == hhv_pkg::ST_OK) begin
			if (cur_pos >= hhv_pkg::MAX_VALUE_LEN) begin
				// over-length: this byte flags malformed and passes as it is
				first_err = hhv_pkg::ST_MALFORMED;
			end else begin
				case (b)
					hhv_pkg::CH_DOT: begin
						if (dot_hit && cur_pos != 0 && dot_idx == cur_pos - 1'b1)
							first_err = hhv_pkg::ST_MALFORMED;
						else begin
							dot_hit = 1'b1;
							dot_idx = cur_pos;
						end
					end
					hhv_pkg::CH_COLON: begin
						if (cur_mode == hhv_pkg::MODE_USUAL) begin
							end_idx   = cur_pos;
							end_fixed = 1'b1;
							cur_mode  = hhv_pkg::MODE_REST;
						end
					end
					hhv_pkg::CH_LBRK: begin
						if (cur_pos == 0)
							cur_mode = hhv_pkg::MODE_LITERAL;
					end
					hhv_pkg::CH_RBRK: begin
						if (cur_mode == hhv_pkg::MODE_LITERAL) begin
							end_idx   = cur_pos + 1'b1;
							end_fixed = 1'b1;
							cur_mode  = hhv_pkg::MODE_REST;
						end
					end
					hhv_pkg::CH_NUL:   first_err = hhv_pkg::ST_MALFORMED;
					hhv_pkg::CH_SLASH: first_err = hhv_pkg::ST_SLASH;
					default: begin
						if (b >= "A" && b <= "Z")
							r.data = b + hhv_pkg::CASE_OFS;
					end
				endcase
				if (first_err == hhv_pkg::ST_OK)
					cur_pos = cur_pos + 1'b1;
			end
		end
		if (l) begin
			if (first_err != hhv_pkg::ST_OK) begin
				r.st = first_err;
			end else begin
				h = end_fixed ? end_idx : cur_pos;
				// one trailing dot on the host part is not counted
				if (h != 0 && dot_hit && dot_idx == h - 1'b1)
					h = h - 1'b1;
				if (h == 0)
					r.st = hhv_pkg::ST_EMPTY;
				else
					r.hlen = hhv_pkg::HLEN_W'(h);
			end
			clear_scan();
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offers one byte from the falling edge and returns once the rising edge has taken it.
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		do @(posedge clk); while (!in_ready);
		host_results_q.push_back(scan_host_byte(b, l));
		bytes_sent++;
	endtask

	task automatic send_value(input host_bytes_t v);
		foreach (v[k])
			send_byte(v[k], k == v.size() - 1);
		values_sent++;
	endtask

	task automatic send_text(input string s);
		host_bytes_t v;
		for (int k = 0; k < s.len(); k++)
			v.push_back(s[k]);
		send_value(v);
	endtask

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	function automatic logic [7:0] label_char();
		case ($urandom_range(0, 3))
			0:       return 8'("a" + $urandom_range(0, 25));
			1:       return 8'("A" + $urandom_range(0, 25));
			2:       return 8'("0" + $urandom_range(0, 9));
			default: return "-";
		endcase
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(0, 5))
			0:       return hhv_pkg::CH_DOT;
			1:       return hhv_pkg::CH_COLON;
			2:       return hhv_pkg::CH_LBRK;
			3:       return hhv_pkg::CH_RBRK;
			4:       return hhv_pkg::CH_SLASH;
			default: return hhv_pkg::CH_NUL;
		endcase
	endfunction

	// Mostly well-formed hosts (name or bracketed literal, optional trailing dot and port),
	// some with one byte broken, and some plain noise.
	function automatic host_bytes_t make_host_value();
		host_bytes_t v;
		int          kind;
		int          labels;
		kind = $urandom_range(0, 99);
		if (kind >= 85) begin
			repeat ($urandom_range(1, 10))
				v.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : special_char());
			return v;
		end
		if ($urandom_range(0, 3) == 0) begin
			v.push_back(hhv_pkg::CH_LBRK);
			repeat ($urandom_range(1, 6))
				v.push_back($urandom_range(0, 2) == 0 ? hhv_pkg::CH_COLON : label_char());
			// now and then the closing bracket is missing
			if ($urandom_range(0, 7) != 0)
				v.push_back(hhv_pkg::CH_RBRK);
		end else begin
			labels = $urandom_range(1, 3);
			for (int k = 0; k < labels; k++) begin
				if (k != 0)
					v.push_back(hhv_pkg::CH_DOT);
				repeat ($urandom_range(1, 5)) v.push_back(label_char());
			end
			if ($urandom_range(0, 3) == 0)
				v.push_back(hhv_pkg::CH_DOT);
		end
		if ($urandom_range(0, 2) == 0) begin
			v.push_back(hhv_pkg::CH_COLON);
			repeat ($urandom_range(0, 4)) v.push_back(8'("0" + $urandom_range(0, 9)));
		end
		if (kind >= 70)
			v[$urandom_range(0, v.size() - 1)] = special_char();
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Receiver side and checking
	// ------------------------------------------------------------------

	// Draws a stall per result; a requested hold is counted out here in cycles.
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			stall = rx_idle_on ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		host_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (host_results_q.size() == 0) begin
				$error("unexpected transaction: out_byte %0h out_last %0b", out_byte, out_last);
				errors++;
			end else begin
				want = host_results_q.pop_front();
				results_checked++;
				if (out_byte !== want.data) begin
					$error("out_byte: expected %0h, got %0h", want.data, out_byte);
					errors++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %0b, got %0b", want.last, out_last);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
				if (host_length !== want.hlen) begin
					$error("host_length: expected %0d, got %0d", want.hlen, host_length);
					errors++;
				end
				if (want.last)
					status_count[want.st]++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Each rule once: literal and port, lowering, trailing dot, double dot, slash,
	// NUL, top-bit byte, empty hosts, brackets in ordinary positions.
	task automatic test_directed();
		send_text("[1]:8");
		send_text("Q.A.");
		send_text("a..b");
		send_text("/X");     // letter after the error must pass unlowered
		send_value('{hhv_pkg::CH_NUL});
		send_value('{8'hFF});
		send_text(".");      // host is only a trailing dot -> empty
		send_text(":");      // port starts at once -> empty
		send_text("a[]");
	endtask

	// Longest value that is still fine, then one that runs past the limit.
	task automatic test_value_lengths();
		host_bytes_t v;
		repeat (hhv_pkg::MAX_VALUE_LEN) v.push_back(label_char());
		send_value(v);
		v.delete();
		repeat (hhv_pkg::MAX_VALUE_LEN + 3) v.push_back(label_char());
		send_value(v);
	endtask

	// Receiver holds off while the sender keeps offering back to back.
	task automatic test_output_stall();
		int start;
		tx_idle_on = 1'b0;
		rx_hold    = 80;
		start      = bytes_sent;
		while (bytes_sent - start < 30)
			send_value(make_host_value());
		tx_idle_on = 1'b1;
	endtask

	task automatic test_random_values(input int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			// occasional stretches with no idling on one side or both
			tx_idle_on = $urandom_range(0, 4) != 0;
			rx_idle_on = $urandom_range(0, 4) != 0;
			send_value(make_host_value());
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_byte    = '0;
		in_last    = 1'b0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold    = 0;
		clear_scan();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_value_lengths();
		test_output_stall();
		test_random_values(1750);

		@(negedge clk);
		in_valid <= 1'b0;

		// drain: wait for the last result, then a short settle
		for (int n = 0; n < 5000 && host_results_q.size() != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (host_results_q.size() != 0) begin
			$error("%0d expected transactions never arrived", host_results_q.size());
			errors += host_results_q.size();
		end

		$display("Covered %0d values in %0d bytes, %0d results checked, incl. full-length",
			values_sent, bytes_sent, results_checked);
		$display("and over-length values; final status ok %0d, malformed %0d, slash %0d, empty %0d",
			status_count[0], status_count[1], status_count[2], status_count[3]);
		if (errors == 0)
			$display("http_host_header_validator: match");
		else
			$display("http_host_header_validator: mismatch");
		$finish;
	end

endmodule
